// ===== src/ccd_pkg.sv =====
`timescale 1ns / 1ps

package ccd_pkg;

  // default sizes
  localparam int unsigned LengthBits = 24;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned CfgW       = 24;

  // container format constants
  localparam int unsigned ChunkHdr = 12;
  localparam int unsigned FileHdr  = 4;
  localparam int unsigned Version  = 1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  // error codes
  localparam logic [2:0] ErrNone        = 3'd0;
  localparam logic [2:0] ErrBadVersion  = 3'd1;
  localparam logic [2:0] ErrShortFile   = 3'd2;
  localparam logic [2:0] ErrTruncHeader = 3'd3;
  localparam logic [2:0] ErrSmallSize   = 3'd4;
  localparam logic [2:0] ErrOverrun     = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  error_code;
    logic [7:0]  chunk_index;
    logic [31:0] signature;
    logic [31:0] hash_word;
    logic [23:0] payload_length;
    logic [7:0]  data_byte;
    logic        chunk_end;
    logic        last;
  } out_t;

  // one queue record: the results caused by one byte
  typedef struct packed {
    out_t       first;
    logic       two;
    kind_e      kind2;
    logic [2:0] err2;
    logic [7:0] idx2;
  } rec_t;

  // result with only kind, code and index set
  function automatic out_t mk_res(kind_e k, logic [2:0] e, logic [7:0] idx);
    out_t r;
    r             = '0;
    r.kind        = k;
    r.error_code  = e;
    r.chunk_index = idx;
    return r;
  endfunction

endpackage

// ===== src/ccd_front.sv =====
`timescale 1ns / 1ps

module ccd_front #(
  parameter int unsigned LENGTH_BITS = ccd_pkg::LengthBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ccd_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                      push_i,
  input  ccd_pkg::in_t              in_data_i,
  input  logic                      q_full_i,
  output logic                      rec_valid_o,
  output ccd_pkg::rec_t             rec_o
);
  import ccd_pkg::*;

  localparam int unsigned WideW = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 2;

  localparam logic [2:0] PhFile = 3'd0;
  localparam logic [2:0] PhChdr = 3'd1;
  localparam logic [2:0] PhPay  = 3'd2;
  localparam logic [2:0] PhDone = 3'd3;
  localparam logic [2:0] PhErr  = 3'd4;

  logic [2:0]             phase_q, phase_d;
  logic [LENGTH_BITS-1:0] pos_q, pos_d;
  logic [3:0]             hdr_q, hdr_d;
  logic [7:0]             total_q, total_d;
  logic [7:0]             seen_q, seen_d;
  logic [31:0]            sig_q, sig_d;
  logic [31:0]            hash_q, hash_d;
  logic [31:0]            size_q, size_d;
  logic [LENGTH_BITS-1:0] pl_q, pl_d;
  logic [LENGTH_BITS-1:0] len_q;

  logic                   accept;
  logic [2:0]             phase_e;
  logic [LENGTH_BITS-1:0] pos_e;
  logic [3:0]             hdr_e;
  logic [7:0]             total_e;
  logic [7:0]             seen_e;
  logic [7:0]             seen_inc;
  logic [7:0]             b;
  logic [31:0]            size_w;
  logic [WideW-1:0]       pos_w;
  logic [WideW-1:0]       len_w;
  logic                   bnd_err;
  logic                   end_err;
  logic [LENGTH_BITS-1:0] pl_hdr;
  logic [LENGTH_BITS-1:0] pl_new;
  rec_t                   rec;
  logic                   rec_v;

  // file length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i) begin
      len_q <= LENGTH_BITS'(cfg_wdata_i);
    end
  end

  // parse one byte
  always_comb begin
    accept   = push_i && !q_full_i;
    b        = in_data_i.in_byte;
    phase_e  = in_data_i.file_start ? PhFile : phase_q;
    pos_e    = in_data_i.file_start ? '0 : pos_q;
    hdr_e    = in_data_i.file_start ? '0 : hdr_q;
    total_e  = in_data_i.file_start ? '0 : total_q;
    seen_e   = in_data_i.file_start ? '0 : seen_q;
    seen_inc = seen_e + 8'd1;
    size_w   = {size_q[23:0], b};
    pos_w    = WideW'(pos_e);
    len_w    = WideW'(len_q);
    // next chunk header must fit behind this byte
    bnd_err  = (pos_w + WideW'(ChunkHdr + 1)) > len_w;
    // chunk end lies past the file
    end_err  = (pos_w + WideW'(size_w) - WideW'(ChunkHdr - 1)) > len_w;
    pl_hdr   = LENGTH_BITS'(size_w - 32'(ChunkHdr));
    pl_new   = (pl_q == '0) ? '0 : pl_q - LENGTH_BITS'(1);

    phase_d = phase_q;
    pos_d   = pos_q;
    hdr_d   = hdr_q;
    total_d = total_q;
    seen_d  = seen_q;
    sig_d   = sig_q;
    hash_d  = hash_q;
    size_d  = size_q;
    pl_d    = pl_q;
    rec     = '0;
    rec_v   = 1'b0;

    if (accept) begin
      phase_d = phase_e;
      pos_d   = pos_e + LENGTH_BITS'(1);
      hdr_d   = hdr_e;
      total_d = total_e;
      seen_d  = seen_e;
      case (phase_e)
        PhFile: begin
          if (pos_e == '0) begin
            if (len_q < LENGTH_BITS'(FileHdr)) begin
              rec.first = mk_res(KIND_ERROR, ErrShortFile, seen_e);
              rec_v     = 1'b1;
              phase_d   = PhErr;
            end else if (b != 8'(Version)) begin
              rec.first = mk_res(KIND_ERROR, ErrBadVersion, seen_e);
              rec_v     = 1'b1;
              phase_d   = PhErr;
            end
          end else if (pos_e == LENGTH_BITS'(1)) begin
            total_d = b;
          end else if (pos_e == LENGTH_BITS'(FileHdr - 1)) begin
            // end of file header: first chunk boundary
            seen_d = '0;
            if (total_e == '0) begin
              rec.first = mk_res(KIND_DONE, ErrNone, 8'd0);
              rec_v     = 1'b1;
              phase_d   = PhDone;
            end else if (bnd_err) begin
              rec.first = mk_res(KIND_ERROR, ErrTruncHeader, 8'd0);
              rec_v     = 1'b1;
              phase_d   = PhErr;
            end else begin
              phase_d = PhChdr;
              hdr_d   = '0;
            end
          end
        end
        PhChdr: begin
          // gather signature, hash and size words, big-endian
          if (hdr_e < 4'd4) begin
            sig_d = {sig_q[23:0], b};
          end else if (hdr_e < 4'd8) begin
            hash_d = {hash_q[23:0], b};
          end else begin
            size_d = size_w;
          end
          hdr_d = hdr_e + 4'd1;
          if (hdr_e == 4'(ChunkHdr - 1)) begin
            hdr_d = '0;
            if (size_w < 32'(ChunkHdr)) begin
              rec.first = mk_res(KIND_ERROR, ErrSmallSize, seen_e);
              rec_v     = 1'b1;
              phase_d   = PhErr;
            end else if (end_err) begin
              rec.first = mk_res(KIND_ERROR, ErrOverrun, seen_e);
              rec_v     = 1'b1;
              phase_d   = PhErr;
            end else begin
              pl_d                     = pl_hdr;
              rec.first                = mk_res(KIND_HEADER, ErrNone, seen_e);
              rec.first.signature      = sig_q;
              rec.first.hash_word      = hash_q;
              rec.first.payload_length = 24'(pl_hdr);
              rec_v                    = 1'b1;
              if (pl_hdr == '0) begin
                // empty payload: chunk ends here
                seen_d = seen_inc;
                if (seen_inc >= total_e) begin
                  rec.two   = 1'b1;
                  rec.kind2 = KIND_DONE;
                  rec.idx2  = seen_inc;
                  phase_d   = PhDone;
                end else if (bnd_err) begin
                  rec.two   = 1'b1;
                  rec.kind2 = KIND_ERROR;
                  rec.err2  = ErrTruncHeader;
                  rec.idx2  = seen_inc;
                  phase_d   = PhErr;
                end else begin
                  phase_d = PhChdr;
                end
              end else begin
                phase_d = PhPay;
              end
            end
          end
        end
        PhPay: begin
          pl_d                = pl_new;
          rec.first           = mk_res(KIND_PAYLOAD, ErrNone, seen_e);
          rec.first.data_byte = b;
          rec.first.chunk_end = (pl_new == '0);
          rec_v               = 1'b1;
          if (pl_new == '0) begin
            seen_d = seen_inc;
            if (seen_inc >= total_e) begin
              rec.two   = 1'b1;
              rec.kind2 = KIND_DONE;
              rec.idx2  = seen_inc;
              phase_d   = PhDone;
            end else if (bnd_err) begin
              rec.two   = 1'b1;
              rec.kind2 = KIND_ERROR;
              rec.err2  = ErrTruncHeader;
              rec.idx2  = seen_inc;
              phase_d   = PhErr;
            end else begin
              phase_d = PhChdr;
              hdr_d   = '0;
            end
          end
        end
        default: begin
          // done or error: bytes are dropped until the next file start
        end
      endcase
      rec.first.last = !rec.two;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFile;
      pos_q   <= '0;
      hdr_q   <= '0;
      total_q <= '0;
      seen_q  <= '0;
      pl_q    <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
      total_q <= total_d;
      seen_q  <= seen_d;
      pl_q    <= pl_d;
    end
  end

  // header shift words
  always_ff @(posedge clk_i) begin
    sig_q  <= sig_d;
    hash_q <= hash_d;
    size_q <= size_d;
  end

  assign rec_valid_o = rec_v;
  assign rec_o       = rec;

endmodule

// ===== src/ccd_queue.sv =====
`timescale 1ns / 1ps

module ccd_queue #(
  parameter int unsigned DEPTH = ccd_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ccd_pkg::rec_t rec_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ccd_pkg::rec_t rec_o
);
  import ccd_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rec_t            mem_q [DEPTH];
  logic [IdxW-1:0] wptr_q, wptr_d;
  logic [IdxW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  // pointer and fill count update
  always_comb begin
    do_push = push_i && (cnt_q != CntW'(DEPTH));
    do_pop  = pop_i && (cnt_q != '0);
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    cnt_d   = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == IdxW'(DEPTH - 1)) ? '0 : wptr_q + IdxW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == IdxW'(DEPTH - 1)) ? '0 : rptr_q + IdxW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // record storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rptr_q];

endmodule

// ===== src/ccd_back.sv =====
`timescale 1ns / 1ps

module ccd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  ccd_pkg::rec_t head_i,
  output logic          deq_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ccd_pkg::out_t out_data_o
);
  import ccd_pkg::*;

  logic sel_q, sel_d;
  out_t res;

  // pick the first or the second result of the head record
  always_comb begin
    if (!sel_q) begin
      res      = head_i.first;
      res.last = !head_i.two;
    end else begin
      res      = mk_res(head_i.kind2, head_i.err2, head_i.idx2);
      res.last = 1'b1;
    end
  end

  // advance within the record, release it after its last result
  always_comb begin
    sel_d = sel_q;
    deq_o = 1'b0;
    if (pop_i && head_valid_i) begin
      if (!sel_q && head_i.two) begin
        sel_d = 1'b1;
      end else begin
        sel_d = 1'b0;
        deq_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

  assign empty_o    = !head_valid_i;
  assign out_data_o = res;

endmodule

// ===== src/chunk_container_deframer.sv =====
`timescale 1ns / 1ps

// Chunk container deframer. Bytes of a file are pushed one per request; a
// byte with file_start set restarts parsing at file byte 0, and cfg_wdata_i
// (written with cfg_we_i) gives the file length. The parser takes one byte
// per cycle while the queue is not full and writes the zero, one or two
// results that byte causes into a record queue of QUEUE_DEPTH entries; full
// rises only when that queue is full. The result side hands out one result
// per cycle while pop is held, so a byte with two results (header or
// payload end plus done or error) holds the port for both; the sustained
// rate is one byte per cycle as long as the consumer pops every cycle and
// such two-result bytes are rare. Results pass through the registered
// queue, behind earlier records. After a done or error result, bytes are
// taken and dropped until the next file start. QUEUE_DEPTH must be 2 or more.
module chunk_container_deframer #(
  parameter int unsigned LENGTH_BITS = ccd_pkg::LengthBits,
  parameter int unsigned QUEUE_DEPTH = ccd_pkg::QueueDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ccd_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                     push,
  output logic                     full,
  input  ccd_pkg::in_t             in_data_i,
  output logic                     empty,
  input  logic                     pop,
  output ccd_pkg::out_t            out_data_o
);
  import ccd_pkg::*;

  logic rec_valid;
  rec_t rec_in;
  logic q_full;
  logic head_valid;
  rec_t head;
  logic deq;

  // byte parser
  ccd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .rec_valid_o(rec_valid),
    .rec_o      (rec_in)
  );

  // record queue between parser and result port
  ccd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_valid),
    .rec_i  (rec_in),
    .full_o (q_full),
    .pop_i  (deq),
    .valid_o(head_valid),
    .rec_o  (head)
  );

  // result sequencer
  ccd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .deq_o       (deq),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_data_o  (out_data_o)
  );

  assign full = q_full;

  // a second result only ever follows a header or payload result
  a_second_after_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.last) |->
      (out_data_o.kind == KIND_HEADER || out_data_o.kind == KIND_PAYLOAD))
    else $error("non-last result of a kind that cannot be followed");

  // error kind and nonzero code go together
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((out_data_o.kind == KIND_ERROR) == (out_data_o.error_code != ErrNone)))
    else $error("error code does not match result kind");

  // chunk end mark only on payload results
  a_chunk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.chunk_end) |-> (out_data_o.kind == KIND_PAYLOAD))
    else $error("chunk end on a non-payload result");

  // parser never makes a record while the queue is full
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid |-> !q_full)
    else $error("record produced while queue full");

endmodule
